FILE: hw/rtl/tmaf_pkg.sv
// ----------------------------------------------------------------------------
// Trimmed-mean filter package
// Shared widths, register map constants and control types.
// ----------------------------------------------------------------------------
package tmaf_pkg;

  localparam int SAMPLE_BITS_DEF   = 24;
  localparam int FRACTION_BITS_DEF = 8;

  localparam int COUNT_W    = 8;   // sample_count register
  localparam int TAKEN_W    = 9;   // samples in window, up to 257
  localparam int OUT_W      = 32;  // average_value
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [COUNT_W-1:0] COUNT_RESET      = 8'd10;
  localparam logic [COUNT_W-1:0] MIN_WINDOW_COUNT = 8'd2;

  // register index, taken from paddr word bit
  localparam logic REG_SAMPLE_COUNT = 1'b0;

  typedef struct packed {
    logic load;    // sample accepted
    logic bypass;  // pass-through mode: sample clears the window
    logic flush;   // window closed, start afresh
  } acc_ctrl_t;

endpackage

FILE: hw/rtl/tmaf_accum.sv
// ----------------------------------------------------------------------------
// Trimmed-mean window accumulator
// Keeps the exact running sum, signed extremes and sample count of a window.
// ----------------------------------------------------------------------------
module tmaf_accum #(
  parameter int SAMPLE_BITS = tmaf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  tmaf_pkg::acc_ctrl_t                   ctrl,
  input  logic signed [SAMPLE_BITS-1:0]         sample,
  input  logic [tmaf_pkg::COUNT_W-1:0]          count,
  output logic signed [SAMPLE_BITS+tmaf_pkg::TAKEN_W-1:0] sum,
  output logic signed [SAMPLE_BITS-1:0]         max_val,
  output logic signed [SAMPLE_BITS-1:0]         min_val,
  output logic                                  last
);

  localparam int SUM_W = SAMPLE_BITS + tmaf_pkg::TAKEN_W;

  logic signed [SUM_W-1:0]              sum_r, sum_nxt;
  logic signed [SAMPLE_BITS-1:0]        max_r, max_nxt;
  logic signed [SAMPLE_BITS-1:0]        min_r, min_nxt;
  logic [tmaf_pkg::TAKEN_W-1:0]         taken_r, taken_nxt;
  logic [tmaf_pkg::TAKEN_W-1:0]         need;

  // the incoming sample closes the window once taken reaches count+1
  assign need = tmaf_pkg::TAKEN_W'(count) + 1'b1;
  assign last = (taken_r >= need);

  always_comb begin
    sum_nxt   = sum_r;
    max_nxt   = max_r;
    min_nxt   = min_r;
    taken_nxt = taken_r;
    if (ctrl.flush || (ctrl.load && ctrl.bypass)) begin
      sum_nxt   = '0;
      max_nxt   = '0;
      min_nxt   = '0;
      taken_nxt = '0;
    end else if (ctrl.load) begin
      if (taken_r == '0) begin
        max_nxt = sample;
        min_nxt = sample;
      end else begin
        if (sample > max_r) max_nxt = sample;
        if (sample < min_r) min_nxt = sample;
      end
      sum_nxt   = sum_r + SUM_W'(sample);
      taken_nxt = taken_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      max_r   <= '0;
      min_r   <= '0;
      taken_r <= '0;
    end else begin
      sum_r   <= sum_nxt;
      max_r   <= max_nxt;
      min_r   <= min_nxt;
      taken_r <= taken_nxt;
    end
  end

  assign sum     = sum_r;
  assign max_val = max_r;
  assign min_val = min_r;

endmodule

FILE: hw/rtl/tmaf_divider.sv
// ----------------------------------------------------------------------------
// Trimmed-mean divider
// Restoring divider, one quotient bit per cycle, on the numerator magnitude.
// ----------------------------------------------------------------------------
module tmaf_divider #(
  parameter int NUM_W = 41
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [NUM_W-1:0]          num,
  input  logic [tmaf_pkg::COUNT_W-1:0]     divisor,
  output logic [NUM_W-1:0]                 quo,
  output logic                             neg,
  output logic                             done
);

  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int DV_W  = tmaf_pkg::COUNT_W;

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DV_W-1:0]  rem_r, rem_nxt;
  logic [DV_W-1:0]  div_r, div_nxt;
  logic             neg_r, neg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DV_W:0]    trial;
  logic [DV_W:0]    diff;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      neg_nxt = num[NUM_W-1];
      quo_nxt = num[NUM_W-1] ? (~num + 1'b1) : num;
      rem_nxt = '0;
      div_nxt = divisor;
      cnt_nxt = CNT_W'(NUM_W);
    end else if (cnt_r != '0) begin
      if (!diff[DV_W]) begin
        rem_nxt = diff[DV_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DV_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    neg_r <= neg_nxt;
  end

  assign quo  = quo_r;
  assign neg  = neg_r;
  assign done = done_r;

endmodule

FILE: hw/rtl/trimmed_mean_adc_filter.sv
// ----------------------------------------------------------------------------
// Trimmed-mean ADC filter
// Olympic average of signed converter samples with an APB count register.
// ----------------------------------------------------------------------------
// With sample_count of 2 or more, a window of sample_count+2 samples is
// collected, one request per cycle, keeping the exact sum and the signed
// largest and smallest samples; the request that closes the window returns
// (sum - largest - smallest) * 2^FRACTION_BITS / sample_count, truncated
// toward zero, and the next window starts. That closing request occupies the
// block through the trim, load, divide and hold states, the restoring
// divider retiring one quotient bit per cycle. With sample_count of 0 or 1
// each sample is returned scaled by 2^FRACTION_BITS and any partial window
// is dropped; each such request holds the block until its result enters the
// output register. A finished result waits in the output register without
// holding up new samples. sample_count sits at byte address 0 and resets to 10.
module trimmed_mean_adc_filter #(
  parameter int SAMPLE_BITS   = tmaf_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = tmaf_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tmaf_pkg::OUT_W-1:0]   out_average_value,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tmaf_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [tmaf_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [tmaf_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int SUM_W  = SAMPLE_BITS + tmaf_pkg::TAKEN_W;
  localparam int TRIM_W = SUM_W + 1;
  localparam int NUM_W  = TRIM_W + FRACTION_BITS;
  localparam int OUT_W  = tmaf_pkg::OUT_W;
  localparam int EXT_W  = SAMPLE_BITS + FRACTION_BITS + OUT_W;
  localparam int QX_W   = NUM_W + OUT_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_TRIM = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_HOLD = 3'd4;

  logic [2:0]                      state_r, state_nxt;
  logic [tmaf_pkg::COUNT_W-1:0]    count_r, count_nxt;
  logic signed [TRIM_W-1:0]        trim_r, trim_nxt;
  logic [OUT_W-1:0]                res_r, res_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]                out_data_r, out_data_nxt;

  logic                            accept;
  logic                            bypass;
  logic                            cfg_wr;
  logic                            reg_sel;
  tmaf_pkg::acc_ctrl_t             acc_ctrl;
  logic signed [SUM_W-1:0]         acc_sum;
  logic signed [SAMPLE_BITS-1:0]   acc_max;
  logic signed [SAMPLE_BITS-1:0]   acc_min;
  logic                            acc_last;
  logic                            div_start;
  logic signed [NUM_W-1:0]         div_num;
  logic [NUM_W-1:0]                div_quo;
  logic                            div_neg;
  logic                            div_done;
  logic signed [EXT_W-1:0]         pass_wide;
  logic [QX_W-1:0]                 qx_mag;
  logic [QX_W-1:0]                 qx_sgn;
  logic                            out_free;

  // config port
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == tmaf_pkg::REG_SAMPLE_COUNT);
  assign cfg_wr  = psel && penable && pwrite && reg_sel;
  assign count_nxt = cfg_wr ? pwdata[tmaf_pkg::COUNT_W-1:0] : count_r;
  assign prdata  = reg_sel ? tmaf_pkg::APB_DATA_W'(count_r) : '0;

  assign bypass   = (count_r < tmaf_pkg::MIN_WINDOW_COUNT);
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign acc_ctrl.load   = accept;
  assign acc_ctrl.bypass = bypass;
  assign acc_ctrl.flush  = (state_r == ST_TRIM);

  tmaf_accum #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (acc_ctrl),
    .sample  (in_sample_value),
    .count   (count_r),
    .sum     (acc_sum),
    .max_val (acc_max),
    .min_val (acc_min),
    .last    (acc_last)
  );

  assign div_start = (state_r == ST_LOAD);
  assign div_num   = NUM_W'(trim_r) <<< FRACTION_BITS;

  tmaf_divider #(
    .NUM_W (NUM_W)
  ) u_divider (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num     (div_num),
    .divisor (count_r),
    .quo     (div_quo),
    .neg     (div_neg),
    .done    (div_done)
  );

  assign pass_wide = EXT_W'(in_sample_value) <<< FRACTION_BITS;
  assign qx_mag    = QX_W'(div_quo);
  assign qx_sgn    = div_neg ? (~qx_mag + 1'b1) : qx_mag;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    trim_nxt      = trim_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (bypass) begin
            res_nxt   = pass_wide[OUT_W-1:0];
            state_nxt = ST_HOLD;
          end else if (acc_last) begin
            state_nxt = ST_TRIM;
          end
        end
      end
      ST_TRIM: begin
        trim_nxt  = TRIM_W'(acc_sum) - TRIM_W'(acc_max) - TRIM_W'(acc_min);
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          res_nxt   = qx_sgn[OUT_W-1:0];
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        // result moves on once the output register is free
        if (out_free) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= tmaf_pkg::COUNT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    trim_r     <= trim_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_average_value = out_data_r;

endmodule
